FILE: rtl/vpts_pkg.sv
// ----------------------------------------------------------------------------
// vpts_pkg
// Shared widths, codes and pipeline types for the vertex projection block.
// ----------------------------------------------------------------------------
package vpts_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COORD_WIDTH = 32;

  // product, truncated term, row sum, divider remainder
  localparam int PROD_W = 2 * COORD_WIDTH;
  localparam int TERM_W = PROD_W - FRAC_BITS;
  localparam int SUM_W  = TERM_W + 2;
  localparam int REM_W  = SUM_W + 2;

  // quotient: one integer bit plus fraction bits
  localparam int QUO_W  = FRAC_BITS + 1;
  localparam int DIV_ST = FRAC_BITS + 2;   // range check stage + one per quotient bit

  // viewport mapping
  localparam int T_W    = FRAC_BITS + 2;
  localparam int DIM_W  = 11;
  localparam int POS_W  = 10;
  localparam int MAP_W  = T_W + DIM_W;
  localparam int SHR_W  = MAP_W - FRAC_BITS - 1;

  localparam logic [QUO_W-1:0] QUO_ONE = QUO_W'(1) << FRAC_BITS;
  localparam logic [T_W-1:0]   T_ONE   = T_W'(1) << FRAC_BITS;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef enum logic {
    REG_COLS = 1'b0,
    REG_ROWS = 1'b1
  } reg_idx_e;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_POINT = 1'b1
  } req_type_e;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic             ovf;
  } div_lane_t;

  typedef struct packed {
    logic [REM_W-1:0] dvs;
    div_lane_t [2:0]  lane;
    logic [2:0]       neg;
    logic             w_zero;
  } div_st_t;

endpackage

FILE: rtl/vertex_project_to_screen.sv
// ----------------------------------------------------------------------------
// vertex_project_to_screen
// Perspective vertex transform by a 4x4 Q16.16 matrix, divide by w, clip test
// and viewport mapping to a character screen.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while the skid register is empty. Load
// transactions (tuser = 0) write one matrix coefficient at once and give no
// result; a point loaded right after sees the new value. Point transactions
// (tuser = 1) give one result each, through the stages multiply, truncate,
// row sum, magnitude, divider range check plus 17 quotient bit stages, clip
// decision, viewport multiply and output register. The three divisions run
// in parallel lanes. Behind the output register sits one skid register; the
// pipeline stalls as a whole only while that skid is occupied.
// A zero w gives the screen center and counts as visible.
// ----------------------------------------------------------------------------
module vertex_project_to_screen (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration (APB style)
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vpts_pkg::PADDR_W-1:0]  paddr,
  input  logic [vpts_pkg::PDATA_W-1:0]  pwdata,
  output logic [vpts_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  // request stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // coef_index[3:0], coef_value[35:4], point_x[67:36], point_y[99:68],
  // point_z[131:100], zero fill
  input  logic [135:0]                  s_axis_tdata_i,
  // req_type[0]
  input  logic                          s_axis_tuser_i,
  // result stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // screen_col[9:0], screen_row[19:10], zero fill
  output logic [23:0]                   m_axis_tdata_o,
  // visible[0]
  output logic                          m_axis_tuser_o
);

  localparam int CW     = vpts_pkg::COORD_WIDTH;
  localparam int NST    = vpts_pkg::DIV_ST + 7;
  localparam int ST_F   = vpts_pkg::DIV_ST + 4;   // clip decision stage
  localparam int ST_M   = ST_F + 1;              // viewport multiply
  localparam int ST_O   = ST_M + 1;              // output register

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [vpts_pkg::DIM_W-1:0] cols_q, rows_q;
  logic                       cfg_wr;
  vpts_pkg::reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = vpts_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= vpts_pkg::DIM_W'(80);
      rows_q <= vpts_pkg::DIM_W'(24);
    end else if (cfg_wr) begin
      case (cfg_idx)
        vpts_pkg::REG_COLS: cols_q <= pwdata[vpts_pkg::DIM_W-1:0];
        vpts_pkg::REG_ROWS: rows_q <= pwdata[vpts_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      vpts_pkg::REG_COLS: prdata = vpts_pkg::PDATA_W'(cols_q);
      vpts_pkg::REG_ROWS: prdata = vpts_pkg::PDATA_W'(rows_q);
      default:            prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Flow control: whole pipeline moves unless the skid register is full
  // --------------------------------------------------------------------------
  logic           en;
  logic           skid_v_q;
  logic [NST-1:0] v_q;
  logic           s_acc;
  logic           is_point;

  assign en              = ~skid_v_q;
  assign s_axis_tready_o = en;
  assign s_acc           = s_axis_tvalid_i & en;
  assign is_point        = (vpts_pkg::req_type_e'(s_axis_tuser_i) == vpts_pkg::REQ_POINT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-2:0], s_axis_tvalid_i & is_point};
    end
  end

  // --------------------------------------------------------------------------
  // Matrix store, written directly on load transactions
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] mat_q [16];
  logic        [3:0]    coef_idx;
  logic signed [CW-1:0] coef_val;
  logic signed [CW-1:0] pt [3];

  assign coef_idx = s_axis_tdata_i[3:0];
  assign coef_val = s_axis_tdata_i[35:4];
  assign pt[0]    = s_axis_tdata_i[67:36];
  assign pt[1]    = s_axis_tdata_i[99:68];
  assign pt[2]    = s_axis_tdata_i[131:100];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) mat_q[i] <= '0;
    end else if (s_acc && !is_point) begin
      mat_q[coef_idx] <= coef_val;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: products; stage 2: truncate toward zero; stage 3: row sums
  // --------------------------------------------------------------------------
  logic signed [vpts_pkg::PROD_W-1:0] prod_q [4][3];
  logic signed [CW-1:0]               m3_q   [4];
  logic signed [CW-1:0]               m3b_q  [4];
  logic signed [vpts_pkg::TERM_W-1:0] term_q [4][3];
  logic signed [vpts_pkg::TERM_W-1:0] term_d [4][3];
  logic signed [vpts_pkg::SUM_W-1:0]  sum_q  [4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (prod_q[r][c][vpts_pkg::PROD_W-1]) begin
          term_d[r][c] = vpts_pkg::TERM_W'(
            (prod_q[r][c] + vpts_pkg::PROD_W'((64'd1 << vpts_pkg::FRAC_BITS) - 64'd1))
            >>> vpts_pkg::FRAC_BITS);
        end else begin
          term_d[r][c] = vpts_pkg::TERM_W'(prod_q[r][c] >>> vpts_pkg::FRAC_BITS);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= vpts_pkg::PROD_W'(mat_q[r*4+c]) * vpts_pkg::PROD_W'(pt[c]);
          term_q[r][c] <= term_d[r][c];
        end
        m3_q[r]  <= mat_q[r*4+3];
        m3b_q[r] <= m3_q[r];
        // constant column times 1.0 is the coefficient itself
        sum_q[r] <= vpts_pkg::SUM_W'(term_q[r][0]) + vpts_pkg::SUM_W'(term_q[r][1])
                  + vpts_pkg::SUM_W'(term_q[r][2]) + vpts_pkg::SUM_W'(m3b_q[r]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: magnitudes and signs for the divider
  // --------------------------------------------------------------------------
  vpts_pkg::div_st_t div_in_d, div_in_q, div_out;

  always_comb begin
    div_in_d = '0;
    div_in_d.dvs    = vpts_pkg::REM_W'(sum_q[3][vpts_pkg::SUM_W-1] ? -sum_q[3] : sum_q[3]);
    div_in_d.w_zero = (sum_q[3] == '0);
    for (int l = 0; l < 3; l++) begin
      div_in_d.lane[l].rem = vpts_pkg::REM_W'(sum_q[l][vpts_pkg::SUM_W-1] ? -sum_q[l]
                                                                           : sum_q[l]);
      div_in_d.neg[l]      = sum_q[l][vpts_pkg::SUM_W-1] ^ sum_q[3][vpts_pkg::SUM_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      div_in_q <= div_in_d;
    end
  end

  vpts_div u_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .din_i  (div_in_q),
    .dout_o (div_out)
  );

  // --------------------------------------------------------------------------
  // Clip decision: each |c| <= 1.0, then offset into [0, 2.0]
  // --------------------------------------------------------------------------
  logic                          vis_d, vis_q, vis_m_q;
  logic signed [vpts_pkg::T_W-1:0] cq [2];
  logic [vpts_pkg::T_W-1:0]      tcol_d, trow_d, tcol_q, trow_q;
  logic [2:0]                    lane_ok;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      lane_ok[l] = ~div_out.lane[l].ovf & (div_out.lane[l].quo <= vpts_pkg::QUO_ONE);
    end
    for (int l = 0; l < 2; l++) begin
      if (div_out.w_zero) begin
        cq[l] = '0;
      end else if (div_out.neg[l]) begin
        cq[l] = -vpts_pkg::T_W'(div_out.lane[l].quo);
      end else begin
        cq[l] = vpts_pkg::T_W'(div_out.lane[l].quo);
      end
    end
    vis_d  = div_out.w_zero | (&lane_ok);
    tcol_d = vpts_pkg::T_ONE + cq[0];
    trow_d = vpts_pkg::T_ONE - cq[1];
  end

  // --------------------------------------------------------------------------
  // Viewport multiply, then scale, saturate and blank when not visible
  // --------------------------------------------------------------------------
  logic [vpts_pkg::DIM_W-1:0] span_c, span_r;
  logic [vpts_pkg::MAP_W-1:0] mcol_q, mrow_q;
  logic [vpts_pkg::SHR_W-1:0] scol, srow;
  logic [vpts_pkg::POS_W-1:0] ocol_d, orow_d;
  logic [vpts_pkg::POS_W-1:0] ocol_q, orow_q, kcol_q, krow_q;
  logic                       ovis_q, kvis_q;

  assign span_c = (cols_q == '0) ? '0 : cols_q - vpts_pkg::DIM_W'(1);
  assign span_r = (rows_q == '0) ? '0 : rows_q - vpts_pkg::DIM_W'(1);
  assign scol   = vpts_pkg::SHR_W'(mcol_q >> (vpts_pkg::FRAC_BITS + 1));
  assign srow   = vpts_pkg::SHR_W'(mrow_q >> (vpts_pkg::FRAC_BITS + 1));

  always_comb begin
    ocol_d = '0;
    orow_d = '0;
    if (vis_m_q) begin
      ocol_d = (scol > vpts_pkg::SHR_W'(vpts_pkg::POS_MAX)) ? vpts_pkg::POS_MAX
                                                           : scol[vpts_pkg::POS_W-1:0];
      orow_d = (srow > vpts_pkg::SHR_W'(vpts_pkg::POS_MAX)) ? vpts_pkg::POS_MAX
                                                           : srow[vpts_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vis_q   <= vis_d;
      tcol_q  <= tcol_d;
      trow_q  <= trow_d;
      vis_m_q <= vis_q;
      mcol_q  <= vpts_pkg::MAP_W'(tcol_q) * vpts_pkg::MAP_W'(span_c);
      mrow_q  <= vpts_pkg::MAP_W'(trow_q) * vpts_pkg::MAP_W'(span_r);
      ovis_q  <= vis_m_q;
      ocol_q  <= ocol_d;
      orow_q  <= orow_d;
    end
    // skid captures the output register when it moves on untaken
    if (en && v_q[ST_O] && !m_axis_tready_i) begin
      kvis_q <= ovis_q;
      kcol_q <= ocol_q;
      krow_q <= orow_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (m_axis_tready_i) skid_v_q <= 1'b0;
    end else if (v_q[ST_O] && !m_axis_tready_i) begin
      skid_v_q <= 1'b1;
    end
  end

  assign m_axis_tvalid_o = skid_v_q | v_q[ST_O];
  assign m_axis_tuser_o  = skid_v_q ? kvis_q : ovis_q;
  assign m_axis_tdata_o  = skid_v_q ? {4'b0, krow_q, kcol_q} : {4'b0, orow_q, ocol_q};

endmodule

FILE: rtl/vpts_div.sv
// ----------------------------------------------------------------------------
// vpts_div
// Three-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vpts_div (
  input  logic             clk_i,
  input  logic             en_i,
  input  vpts_pkg::div_st_t din_i,
  output vpts_pkg::div_st_t dout_o
);

  vpts_pkg::div_st_t st_q [vpts_pkg::DIV_ST];
  vpts_pkg::div_st_t first_d;

  // range check: quotient must stay below 2.0, i.e. |num| < 2*|w|
  always_comb begin
    first_d = din_i;
    for (int l = 0; l < 3; l++) begin
      first_d.lane[l].ovf = (din_i.lane[l].rem >= (din_i.dvs << 1));
      first_d.lane[l].quo = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= first_d;
    end
  end

  for (genvar k = 1; k < vpts_pkg::DIV_ST; k++) begin : g_st
    vpts_pkg::div_st_t       nx;
    logic [vpts_pkg::REM_W-1:0] r2 [3];

    always_comb begin
      nx = st_q[k-1];
      for (int l = 0; l < 3; l++) begin
        // integer bit first, then shift in one fraction bit per stage
        if (k == 1) begin
          r2[l] = st_q[k-1].lane[l].rem;
        end else begin
          r2[l] = st_q[k-1].lane[l].rem << 1;
        end
        if (r2[l] >= st_q[k-1].dvs) begin
          nx.lane[l].rem = r2[l] - st_q[k-1].dvs;
          nx.lane[l].quo = {st_q[k-1].lane[l].quo[vpts_pkg::QUO_W-2:0], 1'b1};
        end else begin
          nx.lane[l].rem = r2[l];
          nx.lane[l].quo = {st_q[k-1].lane[l].quo[vpts_pkg::QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= nx;
      end
    end
  end

  assign dout_o = st_q[vpts_pkg::DIV_ST-1];

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for vertex_project_to_screen.
// ----------------------------------------------------------------------------
// Coefficient loads and point projections are driven on the request stream.
// A scoreboard keeps its own copy of the matrix and the screen size, predicts
// visible/column/row for each accepted point, and checks results in order.
// The matrix kinds used (affine with w = 1, perspective with w = z, fully
// random) are chosen so that plenty of points land inside the clip volume.
// Both streams idle at random, except during one calm phase.
// ----------------------------------------------------------------------------
module tb_top;

  localparam longint ONE       = 64'sd1 <<< 16;
  localparam int     ONE_I     = 32'sd65536;   // 1.0 on a 32-bit field
  localparam int     WDOG_LIMIT = 2000;
  localparam int     DRAIN_CYC  = 40;   // wait that outlasts the point pipeline

  typedef struct {
    bit       vis;
    bit [9:0] col;
    bit [9:0] row;
  } screen_pt_t;

  // --------------------------------------------------------------------------
  // Scoreboard: matrix copy, screen size, queue of expected screen points
  // --------------------------------------------------------------------------
  class proj_scoreboard;
    longint     coef[16];
    bit [10:0]  cols, rows;
    screen_pt_t pending[$];
    int         errors;

    function new();
      foreach (coef[i]) coef[i] = 0;
      cols   = 11'd80;
      rows   = 11'd24;
      errors = 0;
    endfunction

    function void set_screen(vpts_pkg::reg_idx_e r, bit [10:0] v);
      if (r == vpts_pkg::REG_COLS) cols = v;
      else rows = v;
    endfunction

    // (a*b) >> 16, truncated toward zero; no saturation is reachable at 32 bits
    function longint fix_mul(longint a, longint b);
      longint unsigned ua, ub, p;
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      p  = (ua * ub) >> 16;
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function longint row_dot(int r, longint px, longint py, longint pz);
      return fix_mul(coef[4*r], px) + fix_mul(coef[4*r+1], py) +
             fix_mul(coef[4*r+2], pz) + fix_mul(coef[4*r+3], ONE);
    endfunction

    // quotient with 16 fraction bits; returns 0 when magnitude exceeds 2.0
    function bit clip_div(longint num, longint w, output longint q);
      longint unsigned an, aw;
      bit [127:0]      f;
      an = (num < 0) ? -num : num;
      aw = (w < 0) ? -w : w;
      q  = 0;
      if (an / 2 > aw || (an / 2 == aw && an[0])) return 0;
      f = ({64'd0, an} << 16) / aw;
      q = ((num < 0) != (w < 0)) ? -longint'(f[63:0]) : longint'(f[63:0]);
      return 1;
    endfunction

    function bit [9:0] to_screen(longint t, bit [10:0] size);
      longint unsigned span, v;
      span = (size == 0) ? 0 : size - 1;
      v    = (longint'(t) * span) >> 17;
      return (v > 1023) ? 10'd1023 : v[9:0];
    endfunction

    function void note_request(bit is_point, bit [135:0] d);
      longint     p[3], w, c[3];
      bit         ok;
      screen_pt_t e;
      if (!is_point) begin
        coef[d[3:0]] = longint'(signed'(d[35:4]));
        return;
      end
      p[0] = longint'(signed'(d[67:36]));
      p[1] = longint'(signed'(d[99:68]));
      p[2] = longint'(signed'(d[131:100]));
      w  = row_dot(3, p[0], p[1], p[2]);
      ok = 1;
      for (int i = 0; i < 3; i++) begin
        c[i] = 0;
        if (w != 0 && !clip_div(row_dot(i, p[0], p[1], p[2]), w, c[i])) ok = 0;
        if (c[i] < -ONE || c[i] > ONE) ok = 0;
      end
      e = '{0, 0, 0};
      if (ok) begin
        e.vis = 1;
        e.col = to_screen(c[0] + ONE, cols);
        e.row = to_screen(ONE - c[1], rows);
      end
      pending.push_back(e);
    endfunction

    function void check_result(bit vis, bit [9:0] col, bit [9:0] row);
      screen_pt_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result vis=%0d col=%0d row=%0d", $time, vis, col, row);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (vis !== e.vis) begin
        $display("%0t: visible exp %0d got %0d", $time, e.vis, vis);
        errors++;
      end
      if (col !== e.col) begin
        $display("%0t: screen_col exp %0d got %0d", $time, e.col, col);
        errors++;
      end
      if (row !== e.row) begin
        $display("%0t: screen_row exp %0d got %0d", $time, e.row, row);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic                          psel = 0, penable = 0, pwrite = 0;
  logic [vpts_pkg::PADDR_W-1:0]  paddr = '0;
  logic [vpts_pkg::PDATA_W-1:0]  pwdata = '0;
  logic [vpts_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;
  logic                          s_tvalid = 0, s_tready;
  logic [135:0]                  s_tdata = '0;
  logic                          s_tuser = 0;
  logic                          m_tvalid, m_tready = 0;
  logic [23:0]                   m_tdata;
  logic                          m_tuser;

  vertex_project_to_screen dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // idx, coef, x, y, z from bit 0 up
    .s_axis_tuser_i  (s_tuser),   // req_type
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // screen_col, screen_row from bit 0 up
    .m_axis_tuser_o  (m_tuser)    // visible
  );

  proj_scoreboard sb = new();
  bit calm = 0;          // no idling on either side while set
  int idle_cycles = 0;

  // --------------------------------------------------------------------------
  // Monitor: both streams sampled at the edge; watchdog on no progress
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) sb.note_request(s_tuser, s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata[9:0], m_tdata[19:10]);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // receiver backpressure, tready dropped at random with a 9 percent chance
  always @(posedge clk_i)
    m_tready <= calm || ($urandom_range(99) >= 9);

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic send(bit is_point, bit [3:0] idx, logic [31:0] cv,
                      logic [31:0] x, logic [31:0] y, logic [31:0] z);
    if (!calm && $urandom_range(99) < 9) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= is_point;
    s_tdata  <= {4'd0, z, y, x, cv, idx};
    do @(posedge clk_i); while (!(s_tvalid && s_tready));
  endtask

  task automatic load(bit [3:0] idx, logic [31:0] cv);
    send(vpts_pkg::REQ_LOAD, idx, cv, $urandom, $urandom, $urandom);
  endtask

  task automatic point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    send(vpts_pkg::REQ_POINT, 4'($urandom), $urandom, x, y, z);
  endtask

  // sender holds off until every result is back and the pipe has drained
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(vpts_pkg::reg_idx_e r, bit [10:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= vpts_pkg::PADDR_W'(4 * r);
    pwdata  <= {21'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_screen(r, v);
  endtask

  function automatic logic [31:0] rnd_fix(int unsigned lim);
    return 32'($urandom_range(2 * lim)) - 32'(lim);
  endfunction

  // matrix kinds: 0 affine (w = 1), 1 perspective (w = z), 2 fully random
  task automatic load_matrix(int kind);
    for (int i = 0; i < 16; i++) begin
      logic [31:0] v;
      case (kind)
        0: begin
          if (i == 15) v = ONE_I;
          else if (i >= 12) v = 0;
          else if (i % 5 == 0) v = rnd_fix(32'h20000);
          else v = rnd_fix(32'h4000);
        end
        1: begin
          if (i == 14) v = ONE_I;
          else if (i >= 12) v = 0;
          else if (i % 5 == 0) v = ONE_I;
          else v = rnd_fix(32'h2000);
        end
        default: v = $urandom;
      endcase
      load(4'(i), v);
    end
  endtask

  task automatic random_phase(int kind, int n);
    for (int k = 0; k < n; k++) begin
      int sel;
      sel = $urandom_range(99);
      if (sel < 5) load(4'($urandom), (kind == 2) ? $urandom : rnd_fix(32'h20000));
      else if (sel < 15) point($urandom, $urandom, $urandom);
      else if (kind == 1) begin
        logic [31:0] z;
        z = 32'($urandom_range(32'h40000, 32'h8000));
        if ($urandom_range(3) == 0) z = -z;
        point(rnd_fix(z[31] ? -z : z), rnd_fix(z[31] ? -z : z), z);
      end else if (kind == 0) point(rnd_fix(32'h14000), rnd_fix(32'h14000), rnd_fix(32'h14000));
      else point(rnd_fix(32'h30000), rnd_fix(32'h30000), rnd_fix(32'h30000));
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all-zero matrix: w is zero, every point lands in the screen center
    point(32'h7fffffff, 32'h80000000, 32'h0);
    point(32'h80000000, 32'h7fffffff, 32'hffffffff);

    // identity: clip boundaries, just outside, extreme coordinates
    load(4'd0, ONE_I);
    load(4'd5, ONE_I);
    load(4'd10, ONE_I);
    load(4'd15, ONE_I);
    point(ONE_I, ONE_I, ONE_I);
    point(-ONE_I, -ONE_I, -ONE_I);
    point(ONE_I + 1, 0, 0);
    point(0, -ONE_I - 1, 0);
    point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    point(32'h80000000, 32'h80000000, 32'h80000000);
    // tiny w: quotients overflow
    load(4'd15, 32'd1);
    point(32'h100, 0, 0);
    // negative w mirrors the point
    load(4'd15, -ONE_I);
    point(ONE_I / 2, -ONE_I / 4, 0);
    // extreme coefficient values
    load(4'd15, 32'h80000000);
    load(4'd3, 32'h7fffffff);
    point(32'h7fffffff, 32'h80000000, ONE_I);
    load(4'd15, ONE_I);
    load(4'd3, 0);
    point(ONE_I / 3, ONE_I / 5, 0);

    // phases at several screen sizes, the extremes among them
    for (int ph = 0; ph < 6; ph++) begin
      bit [10:0] c, r;
      drain();
      case (ph)
        0: begin c = 1;    r = 1;    end
        1: begin c = 1024; r = 1024; end
        2: begin c = 2047; r = 0;    end
        3: begin c = 0;    r = 2047; end
        4: begin c = 80;   r = 24;   end
        default: begin c = $urandom_range(1024, 1); r = $urandom_range(1024, 1); end
      endcase
      write_reg(vpts_pkg::REG_COLS, c);
      write_reg(vpts_pkg::REG_ROWS, r);
      calm = (ph == 4);
      load_matrix(ph % 3);
      random_phase(ph % 3, 115);
    end

    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

FILE: sim.f
rtl/vpts_pkg.sv
rtl/vpts_div.sv
rtl/vertex_project_to_screen.sv
tb/sv/tb_top.sv
